// ===== hdl/u8t_pkg.sv =====
// shared types, constants and mode codes for the utf-8 transcoder
// no dependencies; used by every module in hdl/
package u8t_pkg;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 3;
  localparam int FIFO_DEPTH_DEF = 2;
  localparam int CP_W           = 21;

  localparam logic [CFG_IDX_W-1:0] REG_ENCODING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_SELECT   = 2'd1;

  localparam logic [2:0] MODE_PLAIN   = 3'd0;
  localparam logic [2:0] MODE_UTF16BE = 3'd1;
  localparam logic [2:0] MODE_UTF16LE = 3'd2;
  localparam logic [2:0] MODE_UTF32BE = 3'd3;
  localparam logic [2:0] MODE_UTF32LE = 3'd4;
  localparam logic [2:0] MODE_LATIN1  = 3'd5;

  localparam logic [CP_W-1:0] CP_FFFD    = 21'h00_FFFD;
  localparam logic [CP_W-1:0] CP_SUPP    = 21'h01_0000;
  localparam logic [31:0]     CP_MAX     = 32'h0010_FFFF;

  typedef enum logic [1:0] {
    TOK_RAW,
    TOK_CP,
    TOK_REPL5
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t       kind;
    logic [CP_W-1:0] cp;
  } token_t;

  typedef struct packed {
    logic [2:0] encoding_mode;
    logic       repl_select;
  } cfg_t;

endpackage

// ===== hdl/u8t_front.sv =====
// front end: gathers code unit bytes, joins surrogates, emits one token per code point
// depends on u8t_pkg
module u8t_front (
  input  logic             clk,
  input  logic             rst_n,
  input  u8t_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_stream,
  input  logic             q_full,
  output logic             q_push,
  output u8t_pkg::token_t  q_tok
);

  logic [31:0] gather_r, gather_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic        pend_r, pend_nxt;

  logic            tok_valid;
  u8t_pkg::token_t tok;
  u8t_pkg::token_t repl_tok;
  logic [31:0]     g;
  logic [31:0]     u32;
  logic [15:0]     u16;
  logic            wide;
  logic            done;
  logic            gathering;

  assign in_ready = !q_full;

  always_comb begin
    repl_tok.kind = cfg.repl_select ? u8t_pkg::TOK_CP : u8t_pkg::TOK_REPL5;
    repl_tok.cp   = u8t_pkg::CP_FFFD;
  end

  always_comb begin
    gather_nxt = gather_r;
    count_nxt  = count_r;
    hs_nxt     = hs_r;
    pend_nxt   = pend_r;
    tok_valid  = 1'b0;
    tok.kind   = u8t_pkg::TOK_RAW;
    tok.cp     = {13'd0, in_data_byte};
    gathering  = (cfg.encoding_mode inside {[u8t_pkg::MODE_UTF16BE:u8t_pkg::MODE_UTF32LE]});
    wide       = (cfg.encoding_mode >= u8t_pkg::MODE_UTF32BE);
    done       = wide ? (count_r == 2'd3) : (count_r != 2'd0);
    g          = {gather_r[23:0], in_data_byte};
    u32        = (cfg.encoding_mode == u8t_pkg::MODE_UTF32LE) ?
                 {g[7:0], g[15:8], g[23:16], g[31:24]} : g;
    u16        = (cfg.encoding_mode == u8t_pkg::MODE_UTF16LE) ? {g[7:0], g[15:8]} : g[15:0];

    if (gathering) begin
      if (done) begin
        gather_nxt = '0;
        count_nxt  = 2'd0;
        if (wide) begin
          tok_valid = 1'b1;
          if (u32 > u8t_pkg::CP_MAX) begin
            tok = repl_tok;
          end else begin
            tok.kind = u8t_pkg::TOK_CP;
            tok.cp   = u32[u8t_pkg::CP_W-1:0];
          end
        end else if (pend_r) begin
          pend_nxt  = 1'b0;
          hs_nxt    = '0;
          tok_valid = 1'b1;
          if (u16 inside {[16'hDC00:16'hDFFF]}) begin
            tok.kind = u8t_pkg::TOK_CP;
            tok.cp   = u8t_pkg::CP_SUPP + {1'b0, hs_r, u16[9:0]};
          end else begin
            tok = repl_tok;
          end
        end else if (u16 inside {[16'hD800:16'hDBFF]}) begin
          pend_nxt = 1'b1;
          hs_nxt   = u16[9:0];
        end else if (u16 inside {[16'hDC00:16'hDFFF]}) begin
          tok_valid = 1'b1;
          tok       = repl_tok;
        end else begin
          tok_valid = 1'b1;
          tok.kind  = u8t_pkg::TOK_CP;
          tok.cp    = {5'd0, u16};
        end
      end else begin
        gather_nxt = g;
        count_nxt  = count_r + 2'd1;
      end
      // a high surrogate left waiting at end of stream still yields one replacement
      if (in_end_of_stream && !wide && pend_nxt && !tok_valid) begin
        tok_valid = 1'b1;
        tok       = repl_tok;
      end
    end else begin
      tok_valid = 1'b1;
      if (cfg.encoding_mode == u8t_pkg::MODE_LATIN1) begin
        tok.kind = u8t_pkg::TOK_CP;
      end
    end

    if (in_end_of_stream) begin
      gather_nxt = '0;
      count_nxt  = 2'd0;
      hs_nxt     = '0;
      pend_nxt   = 1'b0;
    end
  end

  assign q_push = in_valid && in_ready && tok_valid;
  assign q_tok  = tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r <= '0;
      count_r  <= 2'd0;
      hs_r     <= '0;
      pend_r   <= 1'b0;
    end else if (in_valid && in_ready) begin
      gather_r <= gather_nxt;
      count_r  <= count_nxt;
      hs_r     <= hs_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

// ===== hdl/u8t_tok_fifo.sv =====
// short token queue between front and back end
// depends on u8t_pkg
module u8t_tok_fifo #(
  parameter int DEPTH = u8t_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8t_pkg::token_t  push_tok,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output u8t_pkg::token_t  head_tok
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8t_pkg::token_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/u8t_back.sv =====
// back end: expands a token into utf-8 bytes, one per cycle while out_ready allows, through an output register
// depends on u8t_pkg
module u8t_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  u8t_pkg::token_t  q_tok,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_utf8_byte,
  output logic             out_last_of_run
);

  logic [4:0][7:0] cur_bytes_r;
  logic [2:0]      cur_len_r;
  logic [2:0]      idx_r;
  logic            busy_r;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;

  logic [4:0][7:0] enc_bytes;
  logic [2:0]      enc_len;
  logic            adv;
  logic            last;
  logic [u8t_pkg::CP_W-1:0] c;

  always_comb begin
    c         = q_tok.cp;
    enc_bytes = '0;
    enc_len   = 3'd1;
    case (q_tok.kind)
      u8t_pkg::TOK_RAW: begin
        enc_bytes[0] = c[7:0];
      end
      u8t_pkg::TOK_CP: begin
        if (c < 21'h80) begin
          enc_bytes[0] = c[7:0];
        end else if (c < 21'h800) begin
          enc_bytes[0] = {3'b110, c[10:6]};
          enc_bytes[1] = {2'b10, c[5:0]};
          enc_len      = 3'd2;
        end else if (c < 21'h1_0000) begin
          enc_bytes[0] = {4'b1110, c[15:12]};
          enc_bytes[1] = {2'b10, c[11:6]};
          enc_bytes[2] = {2'b10, c[5:0]};
          enc_len      = 3'd3;
        end else begin
          enc_bytes[0] = {5'b11110, c[20:18]};
          enc_bytes[1] = {2'b10, c[17:12]};
          enc_bytes[2] = {2'b10, c[11:6]};
          enc_bytes[3] = {2'b10, c[5:0]};
          enc_len      = 3'd4;
        end
      end
      u8t_pkg::TOK_REPL5: begin
        // U+200000 in the old five-byte form
        enc_bytes = {8'h80, 8'h80, 8'h80, 8'h88, 8'hF8};
        enc_len   = 3'd5;
      end
      default: begin
        enc_bytes[0] = c[7:0];
      end
    endcase
  end

  assign adv   = busy_r && (!out_valid_r || out_ready);
  assign last  = (idx_r == cur_len_r - 3'd1);
  assign q_pop = q_valid && (!busy_r || (adv && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + 3'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= 3'd0;
      end else if (adv && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= cur_bytes_r[idx_r];
      out_last_r <= last;
    end
    if (q_pop) begin
      cur_bytes_r <= enc_bytes;
      cur_len_r   <= enc_len;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_utf8_byte   = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== hdl/utf16_utf32_latin1_to_utf8_transcoder_unit.sv =====
// utf16/utf32/latin1 to utf-8 transcoder, top level
// path: each token is written into the queue, then loaded into the back end, then placed in its output register
// throughput: one input byte per cycle while the queue is not full, one utf-8 byte out per cycle while out_ready
// allows; an item that expands to n bytes is sent out byte by byte by the back end serialiser
// reset (rst_n low, synchronous) clears config to plain mode, gathering state and queue
// depends on u8t_pkg, u8t_front, u8t_tok_fifo, u8t_back
module utf16_utf32_latin1_to_utf8_transcoder_unit #(
  parameter int FIFO_DEPTH = u8t_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [u8t_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [u8t_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_end_of_stream,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_utf8_byte,
  output logic                             out_last_of_run
);

  u8t_pkg::cfg_t   cfg_r;
  logic            q_full;
  logic            q_push;
  u8t_pkg::token_t q_push_tok;
  logic            q_pop;
  logic            q_valid;
  u8t_pkg::token_t q_head_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.encoding_mode <= u8t_pkg::MODE_PLAIN;
      cfg_r.repl_select   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        u8t_pkg::REG_ENCODING_MODE: cfg_r.encoding_mode <= cfg_wdata;
        u8t_pkg::REG_REPL_SELECT:   cfg_r.repl_select   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  u8t_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_tok            (q_push_tok)
  );

  u8t_tok_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (q_push_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_tok   (q_head_tok)
  );

  u8t_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_tok           (q_head_tok),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_utf8_byte   (out_utf8_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== sim/utf16_utf32_latin1_to_utf8_transcoder_unit_tb.sv =====
// self-checking testbench for the utf-8 transcoder: byte stimulus, predicted utf-8 bytes
// depends on u8t_pkg and utf16_utf32_latin1_to_utf8_transcoder_unit from hdl/
`timescale 1ns / 1ps

module utf16_utf32_latin1_to_utf8_transcoder_unit_tb;

  localparam int IDLE_PCT     = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [u8t_pkg::CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
  localparam logic [2:0]                    MODE_SPARE6 = 3'd6;

  localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
  localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] SURR_END        = 16'hE000;

  typedef struct {
    logic [7:0] data_byte;
    logic       end_of_stream;
    bit         drain_first;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
  } utf8_result_t;

  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           cfg_we           = 1'b0;
  logic [u8t_pkg::CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [u8t_pkg::CFG_DATA_W-1:0] cfg_wdata        = '0;
  logic                           in_valid         = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_data_byte     = '0;
  logic                           in_end_of_stream = 1'b0;
  logic                           out_valid;
  logic                           out_ready        = 1'b0;
  logic [7:0]                     out_utf8_byte;
  logic                           out_last_of_run;

  stream_item_t pending_items[$];
  stream_item_t next_item;
  utf8_result_t utf8_expected[$];
  utf8_result_t oldest;
  logic [7:0]   run_bytes[$];

  // predictor copy of the block's registers and gathering state
  logic [2:0]  cur_mode;
  logic        cur_repl;
  logic [31:0] gather_word;
  logic [1:0]  gather_count;
  logic [9:0]  hi_surr_bits;
  logic        surr_waiting;

  int  accepted_items = 0;
  int  offered_items  = 0;
  int  mismatches     = 0;
  int  hold_requests  = 0;
  int  hold_served    = 0;
  int  hold_left      = 0;
  int  cycle_count    = 0;
  bit  idle_on        = 1'b1;

  utf16_utf32_latin1_to_utf8_transcoder_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_utf8_byte    (out_utf8_byte),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_replacement();
    if (cur_repl) begin
      run_bytes.push_back(8'hEF);
      run_bytes.push_back(8'hBF);
      run_bytes.push_back(8'hBD);
    end else begin
      run_bytes.push_back(8'hF8);
      run_bytes.push_back(8'h88);
      run_bytes.push_back(8'h80);
      run_bytes.push_back(8'h80);
      run_bytes.push_back(8'h80);
    end
  endfunction

  function automatic void add_codepoint(input logic [31:0] c);
    if (c < 32'h80) begin
      run_bytes.push_back(c[7:0]);
    end else if (c > u8t_pkg::CP_MAX) begin
      add_replacement();
    end else if (c < 32'h800) begin
      run_bytes.push_back({3'b110, c[10:6]});
      run_bytes.push_back({2'b10, c[5:0]});
    end else if (c < 32'h10000) begin
      run_bytes.push_back({4'b1110, c[15:12]});
      run_bytes.push_back({2'b10, c[11:6]});
      run_bytes.push_back({2'b10, c[5:0]});
    end else begin
      run_bytes.push_back({5'b11110, c[20:18]});
      run_bytes.push_back({2'b10, c[17:12]});
      run_bytes.push_back({2'b10, c[11:6]});
      run_bytes.push_back({2'b10, c[5:0]});
    end
  endfunction

  function automatic void clear_gathering();
    gather_word  = '0;
    gather_count = '0;
    hi_surr_bits = '0;
    surr_waiting = 1'b0;
  endfunction

  function automatic void predict_transcode(input logic [7:0] db, input logic eos);
    logic        wide;
    logic        done;
    logic [31:0] g;
    logic [15:0] u;
    run_bytes.delete();
    if (cur_mode >= u8t_pkg::MODE_UTF16BE && cur_mode <= u8t_pkg::MODE_UTF32LE) begin
      wide = (cur_mode >= u8t_pkg::MODE_UTF32BE);
      // a unit completes on the byte that arrives once the count reaches its width less one, even across mode changes
      done = wide ? (gather_count == 2'd3) : (gather_count != 2'd0);
      gather_word = {gather_word[23:0], db};
      if (done) begin
        g            = gather_word;
        gather_count = '0;
        gather_word  = '0;
        if (wide) begin
          if (cur_mode == u8t_pkg::MODE_UTF32LE) g = {g[7:0], g[15:8], g[23:16], g[31:24]};
          add_codepoint(g);
        end else begin
          u = (cur_mode == u8t_pkg::MODE_UTF16LE) ? {g[7:0], g[15:8]} : g[15:0];
          if (surr_waiting) begin
            surr_waiting = 1'b0;
            if (u >= SURR_LOW_FIRST && u < SURR_END)
              add_codepoint({11'd0, u8t_pkg::CP_SUPP} + {12'd0, hi_surr_bits, u[9:0]});
            else
              add_replacement();
            hi_surr_bits = '0;
          end else if (u >= SURR_HIGH_FIRST && u < SURR_LOW_FIRST) begin
            surr_waiting = 1'b1;
            hi_surr_bits = u[9:0];
          end else if (u >= SURR_LOW_FIRST && u < SURR_END) begin
            add_replacement();
          end else begin
            add_codepoint({16'd0, u});
          end
        end
      end else begin
        gather_count = gather_count + 2'd1;
      end
      if (eos) begin
        if (!wide && surr_waiting && run_bytes.size() == 0) add_replacement();
        clear_gathering();
      end
    end else begin
      if (cur_mode == u8t_pkg::MODE_LATIN1) add_codepoint({24'd0, db});
      else run_bytes.push_back(db);
      if (eos) clear_gathering();
    end
    foreach (run_bytes[k])
      utf8_expected.push_back('{run_bytes[k], k == run_bytes.size() - 1});
  endfunction

  function automatic logic [31:0] random_scalar(input bit with_surrogates);
    case ($urandom_range(0, with_surrogates ? 5 : 4))
      0: return $urandom_range(0, 32'h7F);
      1: return $urandom_range(32'h80, 32'h7FF);
      2: return $urandom_range(32'h800, 32'hD7FF);
      3: return $urandom_range(32'hE000, 32'hFFFF);
      4: return $urandom_range(32'h10000, u8t_pkg::CP_MAX);
      default: return $urandom_range(SURR_HIGH_FIRST, SURR_END - 1);
    endcase
  endfunction

  task automatic write_reg(input logic [u8t_pkg::CFG_IDX_W-1:0] idx,
                           input logic [u8t_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == u8t_pkg::REG_ENCODING_MODE) cur_mode = val;
    else if (idx == u8t_pkg::REG_REPL_SELECT) cur_repl = val[0];
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eos, input bit drain_first);
    pending_items.push_back('{b, eos, drain_first});
  endtask

  task automatic wait_until_drained();
    while (pending_items.size() != 0 || in_valid || utf8_expected.size() != 0) @(posedge clk);
    // room for a transaction that produced nothing to clear the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver: offers at the falling edge, holds until the transaction is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accepted_items == offered_items) begin
      if (pending_items.size() != 0 && !(idle_on && $urandom_range(0, 99) < IDLE_PCT) &&
          !(pending_items[0].drain_first && utf8_expected.size() != 0)) begin
        next_item         = pending_items.pop_front();
        in_valid         <= 1'b1;
        in_data_byte     <= next_item.data_byte;
        in_end_of_stream <= next_item.end_of_stream;
        offered_items    <= offered_items + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and the occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // monitor: checks each output transaction, then predicts for each input transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (utf8_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected output byte %h last %b", out_utf8_byte, out_last_of_run);
        end else begin
          oldest = utf8_expected.pop_front();
          if (oldest.utf8_byte !== out_utf8_byte || oldest.last_of_run !== out_last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected byte %h last %b, got byte %h last %b",
                       oldest.utf8_byte, oldest.last_of_run, out_utf8_byte, out_last_of_run);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_transcode(in_data_byte, in_end_of_stream);
        accepted_items++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("utf16_utf32_latin1_to_utf8_transcoder_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] units[$];
    logic [7:0]  unit_bytes[$];
    logic [31:0] cp;
    logic [31:0] w;
    logic [2:0]  mode;
    logic [1:0]  spare_bits;
    int          pick;
    int          made;
    int          r;
    bit          unit_eos;
    bit          with_pause;

    cur_mode = u8t_pkg::MODE_PLAIN;
    cur_repl = 1'b0;
    clear_gathering();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: pass-through, five-byte replacement
    queue_byte(8'hFF, 1'b1, 1'b0);
    wait_until_drained();

    write_reg(u8t_pkg::REG_ENCODING_MODE, u8t_pkg::MODE_LATIN1);
    queue_byte(8'h7F, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    wait_until_drained();

    // surrogate pair, lone low, high followed by a non-low, high left waiting at end of stream
    write_reg(u8t_pkg::REG_ENCODING_MODE, u8t_pkg::MODE_UTF16BE);
    write_reg(u8t_pkg::REG_REPL_SELECT, 3'b001);
    queue_byte(8'hD8, 1'b0, 1'b0);
    queue_byte(8'h3D, 1'b0, 1'b0);
    queue_byte(8'hDE, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hDC, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hD8, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h41, 1'b0, 1'b0);
    queue_byte(8'hDB, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    wait_until_drained();

    // partial unit dropped at end of stream, then the top of the bmp
    write_reg(u8t_pkg::REG_ENCODING_MODE, u8t_pkg::MODE_UTF16LE);
    write_reg(u8t_pkg::REG_REPL_SELECT, 3'b000);
    queue_byte(8'h41, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    wait_until_drained();

    write_reg(u8t_pkg::REG_ENCODING_MODE, u8t_pkg::MODE_UTF32LE);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h10, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    wait_until_drained();

    // top bit set counts as out of range
    write_reg(u8t_pkg::REG_ENCODING_MODE, u8t_pkg::MODE_UTF32BE);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    wait_until_drained();

    for (int phase = 0; phase < 8; phase++) begin
      pick = $urandom_range(0, 15);
      mode = (pick <= 7) ? pick[2:0] : u8t_pkg::MODE_UTF16BE + pick[1:0];
      if (phase == 6) mode = MODE_SPARE6;
      spare_bits = 2'($urandom_range(0, 3));
      write_reg(u8t_pkg::REG_ENCODING_MODE, mode);
      write_reg(u8t_pkg::REG_REPL_SELECT, {spare_bits, 1'($urandom_range(0, 1))});
      if (phase == 0) write_reg(REG_SPARE, 3'($urandom_range(0, 7)));
      if (phase == 2) hold_requests++;
      if (phase == 4) idle_on = 1'b0;
      with_pause = (phase == 5);

      made = 0;
      while (made < 24) begin
        units.delete();
        unit_bytes.delete();
        r        = $urandom_range(0, 99);
        unit_eos = ($urandom_range(0, 9) == 0);
        if (r < 8) begin
          // stray byte closed by end of stream so alignment recovers
          unit_bytes.push_back(8'($urandom_range(0, 255)));
          unit_eos = 1'b1;
        end else if (mode == u8t_pkg::MODE_UTF16BE || mode == u8t_pkg::MODE_UTF16LE) begin
          if (r < 18) cp = $urandom_range(SURR_HIGH_FIRST, SURR_END - 1);
          else cp = random_scalar(1'b0);
          if (cp > 32'hFFFF) begin
            w = cp - {11'd0, u8t_pkg::CP_SUPP};
            units.push_back(SURR_HIGH_FIRST | {6'd0, w[19:10]});
            units.push_back(SURR_LOW_FIRST | {6'd0, w[9:0]});
          end else begin
            units.push_back(cp[15:0]);
          end
          foreach (units[i]) begin
            if (mode == u8t_pkg::MODE_UTF16LE) begin
              unit_bytes.push_back(units[i][7:0]);
              unit_bytes.push_back(units[i][15:8]);
            end else begin
              unit_bytes.push_back(units[i][15:8]);
              unit_bytes.push_back(units[i][7:0]);
            end
          end
        end else if (mode == u8t_pkg::MODE_UTF32BE || mode == u8t_pkg::MODE_UTF32LE) begin
          w = (r < 20) ? $urandom() : random_scalar(1'b1);
          if (mode == u8t_pkg::MODE_UTF32LE) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
          unit_bytes.push_back(w[31:24]);
          unit_bytes.push_back(w[23:16]);
          unit_bytes.push_back(w[15:8]);
          unit_bytes.push_back(w[7:0]);
        end else begin
          unit_bytes.push_back(8'($urandom_range(0, 255)));
        end
        foreach (unit_bytes[k]) begin
          queue_byte(unit_bytes[k], unit_eos && k == unit_bytes.size() - 1,
                     with_pause && made == 14);
          made++;
        end
      end
      wait_until_drained();
      idle_on = 1'b1;
    end

    if (mismatches == 0 && utf8_expected.size() == 0)
      $display("utf16_utf32_latin1_to_utf8_transcoder_unit verification clean");
    else
      $display("utf16_utf32_latin1_to_utf8_transcoder_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/u8t_pkg.sv
hdl/u8t_front.sv
hdl/u8t_tok_fifo.sv
hdl/u8t_back.sv
hdl/utf16_utf32_latin1_to_utf8_transcoder_unit.sv
sim/utf16_utf32_latin1_to_utf8_transcoder_unit_tb.sv
